FILE: rtl/pdlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdlm_pkg
// Shared types and constants for the peak/decay level meter.
// ----------------------------------------------------------------------------
package pdlm_pkg;

    localparam int VOL_W       = 4;
    localparam int VOL_SHIFT   = 4;
    localparam int NUM_CH      = 8;
    localparam int BAR_W       = 8;
    localparam int NUM_BARS    = 8;
    localparam int LAG_W       = 5;
    localparam int LAG_CODES   = 1 << LAG_W;

    // input item: eight volumes, restart flag, zero padding to 40 bits
    localparam int IN_TDATA_W  = 40;
    localparam int RESTART_BIT = NUM_CH * VOL_W;
    localparam int OUT_TDATA_W = NUM_BARS * BAR_W;

    // configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_DECAY_STEP  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DISPLAY_LAG = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MONO_MODE   = 2'd2;

    localparam logic [BAR_W-1:0] DECAY_STEP_RST  = 8'd8;
    localparam logic [LAG_W-1:0] DISPLAY_LAG_RST = 5'd0;
    localparam logic             MONO_MODE_RST   = 1'b1;

    typedef logic [VOL_W-1:0] vol_t;
    typedef logic [BAR_W-1:0] level_t;

endpackage

FILE: rtl/pdlm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdlm_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module pdlm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: rtl/pdlm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdlm_lane
// One meter lane: peak capture, otherwise linear decay clamped at zero.
// ----------------------------------------------------------------------------
module pdlm_lane
    import pdlm_pkg::*;
(
    input  vol_t   vol,
    input  level_t old_level,
    input  level_t decay_step,
    output level_t new_level
);

    level_t scaled;

    always_comb
    begin
        scaled = level_t'({vol, {VOL_SHIFT{1'b0}}});
        if (old_level < scaled)
        begin
            new_level = scaled;
        end
        else if (old_level > decay_step)
        begin
            new_level = old_level - decay_step;
        end
        else
        begin
            new_level = '0;
        end
    end

endmodule

FILE: rtl/peak_decay_level_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peak_decay_level_meter
// Multi-lane peak-hold level meter with linear decay and a delay ring.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  8 x 4-bit volume, restart
//  m_axis    out  m_axis_tvalid / m_axis_tready  8 x 8-bit bar level
//  cfg       in   cfg_we (no stall)              decay_step, display_lag, mono
//
//  One item per cycle unless m_axis stalls. The accept edge issues the ring
//  reads; the advancing compute stage writes the row and result register.
//  Reset clears pointers, config and the ring valid bits (unwritten rows read
//  as zero), so no clearing pass is needed. A stall on m_axis holds the item
//  in the compute stage; s_axis_tready follows m_axis_tready combinationally.
// ----------------------------------------------------------------------------
module peak_decay_level_meter
    import pdlm_pkg::*;
#(
    parameter int RING_DEPTH = 20,
    parameter int LANES      = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [3:0] vol_ch0 .. [31:28] vol_ch7, [32] restart, [39:33] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] bar0, [15:8] bar1 .. [63:56] bar7
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int ROW_W = LANES * BAR_W;
    localparam int VOLS_W = NUM_CH * VOL_W;

    // configuration
    level_t           decay_step_reg;
    logic [LAG_W-1:0] display_lag_reg;
    logic             mono_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_step_reg  <= DECAY_STEP_RST;
            display_lag_reg <= DISPLAY_LAG_RST;
            mono_mode_reg   <= MONO_MODE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DECAY_STEP:  decay_step_reg  <= cfg_wdata[BAR_W-1:0];
                REG_DISPLAY_LAG: display_lag_reg <= cfg_wdata[LAG_W-1:0];
                REG_MONO_MODE:   mono_mode_reg   <= cfg_wdata[0];
                default:         ;
            endcase
        end
    end

    // lag reduced modulo ring depth through a constant lookup
    logic [AW-1:0] lag_slot;

    always_comb
    begin
        lag_slot = '0;
        for (int k = 0; k < LAG_CODES; k++)
        begin
            if (display_lag_reg == LAG_W'(k))
            begin
                lag_slot = AW'(k % RING_DEPTH);
            end
        end
    end

    // handshake / stage control
    logic s_valid_reg;
    logic out_valid_reg;
    logic s_advance;
    logic accept;

    assign s_advance     = s_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !s_valid_reg || s_advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // issue: pointers and ring read addresses
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW-1:0] iss_wr, iss_rd, iss_prev;
    logic          restart;

    assign restart = s_axis_tdata[RESTART_BIT];

    always_comb
    begin
        iss_wr   = restart ? lag_slot : wr_ptr_reg;
        iss_rd   = restart ? '0 : rd_ptr_reg;
        iss_prev = (iss_wr == '0) ? AW'(RING_DEPTH - 1) : iss_wr - AW'(1);
        wr_ptr_next = (iss_wr == AW'(RING_DEPTH - 1)) ? '0 : iss_wr + AW'(1);
        rd_ptr_next = (iss_rd == AW'(RING_DEPTH - 1)) ? '0 : iss_rd + AW'(1);
    end

    // compute stage registers
    logic [VOLS_W-1:0]     s_vols_reg;
    logic [AW-1:0]         s_wr_reg;
    logic [AW-1:0]         s_rd_reg;
    logic                  s_prev_fwd_reg, s_prev_vld_reg;
    logic                  s_rd_fwd_reg, s_rd_vld_reg;
    logic [RING_DEPTH-1:0] ring_vld_reg;
    logic [ROW_W-1:0]      last_row_reg;

    logic [ROW_W-1:0]      new_row;
    logic [ROW_W-1:0]      ram_prev, ram_rd;
    logic [ROW_W-1:0]      prev_row, rd_row, shown_row;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            s_valid_reg  <= 1'b0;
            ring_vld_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= rd_ptr_next;
            end
            if (accept)
            begin
                s_valid_reg <= 1'b1;
            end
            else if (s_advance)
            begin
                s_valid_reg <= 1'b0;
            end
            if (s_advance)
            begin
                ring_vld_reg[s_wr_reg] <= 1'b1;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s_vols_reg     <= s_axis_tdata[VOLS_W-1:0];
            s_wr_reg       <= iss_wr;
            s_rd_reg       <= iss_rd;
            // a row written on this same edge is missed by the RAM read
            s_prev_fwd_reg <= s_advance && (s_wr_reg == iss_prev);
            s_rd_fwd_reg   <= s_advance && (s_wr_reg == iss_rd);
            s_prev_vld_reg <= ring_vld_reg[iss_prev];
            s_rd_vld_reg   <= ring_vld_reg[iss_rd];
        end
        if (s_advance)
        begin
            last_row_reg <= new_row;
        end
    end

    pdlm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .we      (s_advance),
        .waddr   (s_wr_reg),
        .wdata   (new_row),
        .re      (accept),
        .raddr_a (iss_prev),
        .raddr_b (iss_rd),
        .rdata_a (ram_prev),
        .rdata_b (ram_rd)
    );

    always_comb
    begin
        if (s_prev_fwd_reg)
        begin
            prev_row = last_row_reg;
        end
        else if (s_prev_vld_reg)
        begin
            prev_row = ram_prev;
        end
        else
        begin
            prev_row = '0;
        end

        if (s_rd_fwd_reg)
        begin
            rd_row = last_row_reg;
        end
        else if (s_rd_vld_reg)
        begin
            rd_row = ram_rd;
        end
        else
        begin
            rd_row = '0;
        end

        // zero lag: the row written by this item is the one shown
        shown_row = (s_rd_reg == s_wr_reg) ? new_row : rd_row;
    end

    // lanes
    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        localparam int CH_MONO   = (i / 2) % NUM_CH;
        localparam int CH_STEREO = i % NUM_CH;

        vol_t lane_vol;

        assign lane_vol = mono_mode_reg ? s_vols_reg[CH_MONO*VOL_W +: VOL_W]
                                        : s_vols_reg[CH_STEREO*VOL_W +: VOL_W];

        pdlm_lane u_lane (
            .vol        (lane_vol),
            .old_level  (prev_row[i*BAR_W +: BAR_W]),
            .decay_step (decay_step_reg),
            .new_level  (new_row[i*BAR_W +: BAR_W])
        );
    end

    // result register
    logic [OUT_TDATA_W-1:0] out_bars;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    for (genvar b = 0; b < NUM_BARS; b++)
    begin : g_bar
        if (b < LANES)
        begin : g_used
            assign out_bars[b*BAR_W +: BAR_W] = shown_row[b*BAR_W +: BAR_W];
        end
        else
        begin : g_unused
            assign out_bars[b*BAR_W +: BAR_W] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_advance)
        begin
            out_data_reg <= out_bars;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

FILE: bench/tb_peak_decay_level_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_peak_decay_level_meter
// Self-checking bench for the eight-lane peak/decay level meter. Ticks go in
// on s_axis, a local model of the level ring predicts each displayed row, and
// every m_axis item is compared bar by bar. Covers decay clamp and hold, mono
// and stereo lane mapping, restart with in-range and out-of-range lag, random
// ticks under several register settings, and input/output backpressure.
// ----------------------------------------------------------------------------
module tb_peak_decay_level_meter;
    import pdlm_pkg::*;

    localparam int RING_SLOTS   = 20;
    localparam int LANE_CNT     = 8;
    localparam int IDLE_PCT     = 20;
    localparam int STALL_CYCLES = 80;
    localparam int SETTLE_WAIT  = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_PRINTS   = 40;

    // index with no register behind it; writes must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic                          restart;
        logic [NUM_CH-1:0][VOL_W-1:0]  vol;
    } tick_t;

    logic                   clk;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [3:0] vol_ch0 .. [31:28] vol_ch7, [32] restart, [39:33] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [7:0] bar0, [15:8] bar1 .. [63:56] bar7
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata     = '0;

    // model state
    level_t     lvl_ring [RING_SLOTS][LANE_CNT];
    int         wr_slot;
    int         rd_slot;
    level_t     cfg_decay;
    logic [LAG_W-1:0] cfg_lag;
    logic       cfg_mono;

    logic [OUT_TDATA_W-1:0] rows_due [$];
    int         err_cnt   = 0;
    int         cycle_cnt = 0;
    logic       no_idle   = 1'b0;
    logic       hold_go   = 1'b0;
    logic       hold_go_q = 1'b0;
    int         hold_left = 0;

    peak_decay_level_meter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("tb_peak_decay_level_meter NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (err_cnt < MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic void meter_reset();
        for (int s = 0; s < RING_SLOTS; s++)
            for (int i = 0; i < LANE_CNT; i++)
                lvl_ring[s][i] = '0;
        wr_slot   = 0;
        rd_slot   = 0;
        cfg_decay = DECAY_STEP_RST;
        cfg_lag   = DISPLAY_LAG_RST;
        cfg_mono  = MONO_MODE_RST;
    endfunction

    // one display tick: update the ring, return the row shown
    function automatic logic [OUT_TDATA_W-1:0] meter_tick(input tick_t t);
        int prev_slot;
        int ch;
        level_t scaled;
        level_t old_lvl;
        level_t new_lvl;
        logic [OUT_TDATA_W-1:0] row;
        row = '0;
        if (t.restart)
        begin
            wr_slot = int'(cfg_lag) % RING_SLOTS;
            rd_slot = 0;
        end
        prev_slot = (wr_slot + RING_SLOTS - 1) % RING_SLOTS;
        for (int i = 0; i < LANE_CNT; i++)
        begin
            ch      = (cfg_mono ? (i >> 1) : i) % NUM_CH;
            scaled  = level_t'(t.vol[ch]) << VOL_SHIFT;
            old_lvl = lvl_ring[prev_slot][i];
            if (old_lvl < scaled)
                new_lvl = scaled;
            else if (old_lvl > cfg_decay)
                new_lvl = old_lvl - cfg_decay;
            else
                new_lvl = '0;
            lvl_ring[wr_slot][i] = new_lvl;
        end
        for (int i = 0; i < LANE_CNT; i++)
            row[i*BAR_W +: BAR_W] = lvl_ring[rd_slot][i];
        wr_slot = (wr_slot + 1) % RING_SLOTS;
        rd_slot = (rd_slot + 1) % RING_SLOTS;
        return row;
    endfunction

    function automatic tick_t tick_of(input logic [31:0] vols, input logic rs);
        tick_t t;
        t.vol     = vols;
        t.restart = rs;
        return t;
    endfunction

    // volumes lean toward silence and full scale so decay and peaks both show
    function automatic tick_t rand_tick(input int restart_pct);
        tick_t t;
        int sel;
        for (int k = 0; k < NUM_CH; k++)
        begin
            sel = $urandom_range(0, 3);
            if (sel == 0)
                t.vol[k] = '0;
            else if (sel == 1)
                t.vol[k] = '1;
            else
                t.vol[k] = vol_t'($urandom_range(0, 15));
        end
        t.restart = ($urandom_range(0, 99) < restart_pct);
        return t;
    endfunction

    task automatic send_tick(input tick_t t);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(t);
        do
            @(posedge clk);
        while (!s_axis_tready);
        rows_due.push_back(meter_tick(t));
        if (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // stop sending and wait for every pending row
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (rows_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic set_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_DECAY_STEP:  cfg_decay = value;
            REG_DISPLAY_LAG: cfg_lag   = value[LAG_W-1:0];
            REG_MONO_MODE:   cfg_mono  = value[0];
            default: ;
        endcase
    endtask

    task automatic check_row(input logic [OUT_TDATA_W-1:0] got);
        logic [OUT_TDATA_W-1:0] want;
        if (rows_due.size() == 0)
        begin
            report_mismatch($sformatf("row %h with no tick pending", got));
            return;
        end
        want = rows_due.pop_front();
        for (int i = 0; i < NUM_BARS; i++)
            if (got[i*BAR_W +: BAR_W] !== want[i*BAR_W +: BAR_W])
                report_mismatch($sformatf("bar%0d got %0d want %0d", i,
                                got[i*BAR_W +: BAR_W], want[i*BAR_W +: BAR_W]));
    endtask

    // result side: check, then pick next tready (long hold on request)
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_row(m_axis_tdata);
            hold_go_q <= hold_go;
            if (hold_go && !hold_go_q)
                hold_left = STALL_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    task automatic test_directed();
        send_tick(tick_of(32'h0000_0000, 1'b0));    // previous row wraps to last slot
        send_tick(tick_of(32'hFFFF_FFFF, 1'b0));
        send_tick(tick_of(32'h0000_0000, 1'b0));
        send_tick(tick_of(32'hFFFF_0000, 1'b0));    // upper channels unused in mono
        set_reg(REG_DECAY_STEP, 8'd255);            // decrement larger than level
        send_tick(tick_of(32'h0000_0000, 1'b0));
        send_tick(tick_of(32'h0000_0F81, 1'b0));
        set_reg(REG_DECAY_STEP, 8'd0);              // levels hold
        send_tick(tick_of(32'h0000_0000, 1'b0));
        set_reg(REG_MONO_MODE, 8'd0);
        send_tick(tick_of(32'hFDB9_7531, 1'b0));
        send_tick(tick_of(32'h0246_8ACE, 1'b0));
        set_reg(REG_DISPLAY_LAG, 8'd19);
        send_tick(tick_of(32'hFFFF_FFFF, 1'b1));
        send_tick(tick_of(32'h1234_5678, 1'b0));
        send_tick(tick_of(32'h8765_4321, 1'b0));
        set_reg(REG_DISPLAY_LAG, 8'd25);            // lag past ring depth wraps
        send_tick(tick_of(32'hA5A5_A5A5, 1'b1));
        send_tick(tick_of(32'h5A5A_5A5A, 1'b0));
        set_reg(REG_DISPLAY_LAG, 8'd31);
        send_tick(tick_of(32'hFFFF_FFFF, 1'b1));
        send_tick(tick_of(32'h0000_0000, 1'b0));
        set_reg(REG_DECAY_STEP, 8'd1);
        send_tick(tick_of(32'h0000_0000, 1'b0));
        set_reg(REG_UNUSED, 8'hFF);
        send_tick(tick_of(32'h0000_0000, 1'b0));
        set_reg(REG_DISPLAY_LAG, 8'd0);             // zero lag shows current row
        send_tick(tick_of(32'h0F0F_F0F0, 1'b1));
    endtask

    task automatic test_random_phases();
        int decay_set [8] = '{8, 0, 255, 1, 16, -1, 40, 3};
        int lag_set   [8] = '{0, 19, 31, 20, 7, -1, 1, 12};
        int mono_set  [8] = '{1, 0, 1, 0, 0, 1, 0, 1};
        tick_t first_t;
        for (int p = 0; p < 8; p++)
        begin
            set_reg(REG_DECAY_STEP, (decay_set[p] < 0) ? 8'($urandom_range(0, 255))
                                                       : 8'(decay_set[p]));
            set_reg(REG_DISPLAY_LAG, (lag_set[p] < 0) ? 8'($urandom_range(0, 31))
                                                      : 8'(lag_set[p]));
            set_reg(REG_MONO_MODE, 8'(mono_set[p]));
            no_idle <= (p == 2);                    // one stretch at full rate
            for (int n = 0; n < 75; n++)
            begin
                if (n == 0)
                begin
                    first_t         = rand_tick(0);
                    first_t.restart = 1'b1;
                    send_tick(first_t);
                end
                else
                begin
                    send_tick(rand_tick(4));
                end
            end
        end
        no_idle <= 1'b0;
    endtask

    // receiver holds off while ticks keep coming; input must back up
    task automatic test_output_stall();
        settle();
        hold_go <= 1'b1;
        for (int n = 0; n < 30; n++)
            send_tick(rand_tick(3));
        hold_go <= 1'b0;
    endtask

    // sender stops until everything is out, then resumes
    task automatic test_drain_pause();
        for (int n = 0; n < 10; n++)
            send_tick(rand_tick(5));
        settle();
        for (int n = 0; n < 10; n++)
            send_tick(rand_tick(5));
    endtask

    initial
    begin
        meter_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_output_stall();
        test_random_phases();
        test_drain_pause();
        settle();
        if (err_cnt == 0)
            $display("tb_peak_decay_level_meter OK");
        else
            $display("tb_peak_decay_level_meter NOT OK");
        $finish;
    end

endmodule
